// ===== rtl/gtpu_pkg.sv =====
package gtpu_pkg;

	localparam logic KIND_REG   = 1'b0;
	localparam logic KIND_IMAGE = 1'b1;

	// Tag format field
	localparam logic [1:0] FLG_PACKED = 2'd0;
	localparam logic [1:0] FLG_LIST   = 2'd1;

	// Packed register descriptors with special handling
	localparam logic [3:0] DESC_PRIM  = 4'h0;
	localparam logic [3:0] DESC_RGBAQ = 4'h1;
	localparam logic [3:0] DESC_ST    = 4'h2;
	localparam logic [3:0] DESC_UV    = 4'h3;
	localparam logic [3:0] DESC_XYZF2 = 4'h4;
	localparam logic [3:0] DESC_XYZ2  = 4'h5;
	localparam logic [3:0] DESC_AD    = 4'he;
	localparam logic [3:0] DESC_NOP   = 4'hf;

	// Target register numbers
	localparam logic [7:0] REG_PRIM  = 8'h00;
	localparam logic [7:0] REG_RGBAQ = 8'h01;
	localparam logic [7:0] REG_ST    = 8'h02;
	localparam logic [7:0] REG_UV    = 8'h03;
	localparam logic [7:0] REG_XYZF2 = 8'h04;
	localparam logic [7:0] REG_XYZ2  = 8'h05;
	localparam logic [7:0] REG_XYZF3 = 8'h0c;
	localparam logic [7:0] REG_XYZ3  = 8'h0d;

	typedef struct packed {
		logic        kind;
		logic [7:0]  reg_addr;
		logic [63:0] data_low;
		logic [63:0] data_high;
		logic        last;
	} res_t;

	// Results of one quadword: count (0..2) and the two result slots.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} gtpu_out_t;

endpackage

// ===== rtl/gtpu_core.sv =====
module gtpu_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [63:0]           qword_low,
	input  logic [63:0]           qword_high,
	output gtpu_pkg::gtpu_out_t   res
);

	typedef enum logic [1:0] {
		MODE_TAG,
		MODE_PACKED,
		MODE_LIST,
		MODE_IMAGE
	} mode_t;

	mode_t       mode_q, mode_n, mode_eff;
	logic [14:0] loops_q, loops_n;
	logic [4:0]  rpl_q, rpl_n;
	logic [3:0]  idx_q, idx_n;
	logic [63:0] desc_q, desc_n;
	logic [31:0] rgba_q, rgba_n;
	logic [31:0] qv_q, qv_n;

	// Step to the next descriptor; returns {next index, next loop count}.
	function automatic logic [18:0] advance(input logic [3:0] idx, input logic [4:0] rpl,
			input logic [14:0] loops);
		logic [4:0] n;
		n = {1'b0, idx} + 5'd1;
		if (n >= rpl) begin
			advance = {4'd0, loops - 15'd1};
		end else begin
			advance = {n[3:0], loops};
		end
	endfunction

	logic [31:0] w0, w1, w2, w3;
	logic [3:0]  d0, d1;
	logic [18:0] adv0, adv1;
	logic [31:0] uv_a, xyz_b;
	logic        pre;
	logic [3:0]  nreg;

	assign w0 = qword_low[31:0];
	assign w1 = qword_low[63:32];
	assign w2 = qword_high[31:0];
	assign w3 = qword_high[63:32];

	always_comb begin
		res      = '0;
		mode_n   = mode_q;
		loops_n  = loops_q;
		rpl_n    = rpl_q;
		idx_n    = idx_q;
		desc_n   = desc_q;
		rgba_n   = rgba_q;
		qv_n     = qv_q;
		d0       = desc_q[{idx_q, 2'b00} +: 4];
		adv0     = advance(idx_q, rpl_q, loops_q);
		d1       = desc_q[{adv0[18:15], 2'b00} +: 4];
		adv1     = advance(adv0[18:15], rpl_q, adv0[14:0]);
		pre      = qword_low[46];
		nreg     = qword_low[63:60];
		uv_a     = {1'b0, w1[14:0], 1'b0, w0[14:0]};
		xyz_b    = {w3[11:4], w2[27:4]};
		mode_eff = (mode_q != MODE_TAG && loops_q == 15'd0) ? MODE_TAG : mode_q;

		unique case (mode_eff)
			MODE_TAG: begin
				loops_n = qword_low[14:0];
				rpl_n   = (nreg == 4'd0) ? 5'd16 : {1'b0, nreg};
				if (qword_low[59:58] == gtpu_pkg::FLG_PACKED) begin
					desc_n = qword_high;
					idx_n  = 4'd0;
					mode_n = MODE_PACKED;
					if (pre) begin
						res.cnt         = 2'd1;
						res.r0.reg_addr = gtpu_pkg::REG_PRIM;
						res.r0.data_low = {53'd0, qword_low[57:47]};
					end
				end else if (qword_low[59:58] == gtpu_pkg::FLG_LIST) begin
					desc_n = qword_high;
					idx_n  = 4'd0;
					mode_n = MODE_LIST;
				end else begin
					mode_n = MODE_IMAGE;
				end
			end
			MODE_PACKED: begin
				res.cnt = 2'd1;
				res.r0.kind = gtpu_pkg::KIND_REG;
				case (d0)
					gtpu_pkg::DESC_PRIM: begin
						res.r0.reg_addr = gtpu_pkg::REG_PRIM;
						res.r0.data_low = {32'd0, w0};
					end
					gtpu_pkg::DESC_RGBAQ: begin
						res.r0.reg_addr = gtpu_pkg::REG_RGBAQ;
						res.r0.data_low = {qv_q, w3[7:0], w2[7:0], w1[7:0], w0[7:0]};
					end
					gtpu_pkg::DESC_ST: begin
						res.cnt         = 2'd2;
						res.r0.reg_addr = gtpu_pkg::REG_ST;
						res.r0.data_low = qword_low;
						res.r1.reg_addr = gtpu_pkg::REG_RGBAQ;
						res.r1.data_low = {w2, rgba_q};
					end
					gtpu_pkg::DESC_UV: begin
						res.r0.reg_addr = gtpu_pkg::REG_UV;
						res.r0.data_low = {32'd0, uv_a};
					end
					gtpu_pkg::DESC_XYZF2: begin
						res.r0.reg_addr = w3[15] ? gtpu_pkg::REG_XYZF3 : gtpu_pkg::REG_XYZF2;
						res.r0.data_low = {xyz_b, w1[15:0], w0[15:0]};
					end
					gtpu_pkg::DESC_XYZ2: begin
						res.r0.reg_addr = w3[15] ? gtpu_pkg::REG_XYZ3 : gtpu_pkg::REG_XYZ2;
						res.r0.data_low = {w2, w1[15:0], w0[15:0]};
					end
					gtpu_pkg::DESC_AD: begin
						res.r0.reg_addr = w2[7:0];
						res.r0.data_low = qword_low;
					end
					gtpu_pkg::DESC_NOP: begin
						res.cnt = 2'd0;
					end
					default: begin
						res.r0.reg_addr = {4'd0, d0};
						res.r0.data_low = qword_low;
					end
				endcase
				idx_n   = adv0[18:15];
				loops_n = adv0[14:0];
			end
			MODE_LIST: begin
				res.cnt         = 2'd1;
				res.r0.reg_addr = {4'd0, d0};
				res.r0.data_low = qword_low;
				idx_n           = adv0[18:15];
				loops_n         = adv0[14:0];
				// When the loops end on the low half, the high half is padding.
				if (adv0[14:0] != 15'd0) begin
					res.cnt         = 2'd2;
					res.r1.reg_addr = {4'd0, d1};
					res.r1.data_low = qword_high;
					idx_n           = adv1[18:15];
					loops_n         = adv1[14:0];
				end
			end
			MODE_IMAGE: begin
				res.cnt          = 2'd1;
				res.r0.kind      = gtpu_pkg::KIND_IMAGE;
				res.r0.data_low  = qword_low;
				res.r0.data_high = qword_high;
				loops_n          = loops_q - 15'd1;
			end
			default: begin
				res.cnt = 2'd0;
			end
		endcase

		if (loops_n == 15'd0) begin
			mode_n = MODE_TAG;
		end

		if (res.cnt == 2'd2) begin
			res.r1.last = 1'b1;
		end else if (res.cnt == 2'd1) begin
			res.r0.last = 1'b1;
		end

		// A write to RGBAQ refreshes the stored color and Q; the later write wins.
		if (res.cnt == 2'd2 && res.r1.kind == gtpu_pkg::KIND_REG
				&& res.r1.reg_addr == gtpu_pkg::REG_RGBAQ) begin
			rgba_n = res.r1.data_low[31:0];
			qv_n   = res.r1.data_low[63:32];
		end else if (res.cnt != 2'd0 && res.r0.kind == gtpu_pkg::KIND_REG
				&& res.r0.reg_addr == gtpu_pkg::REG_RGBAQ) begin
			rgba_n = res.r0.data_low[31:0];
			qv_n   = res.r0.data_low[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TAG;
			loops_q <= '0;
			rpl_q   <= '0;
			idx_q   <= '0;
			desc_q  <= '0;
			rgba_q  <= '0;
			qv_q    <= '0;
		end else if (fire) begin
			mode_q  <= mode_n;
			loops_q <= loops_n;
			rpl_q   <= rpl_n;
			idx_q   <= idx_n;
			desc_q  <= desc_n;
			rgba_q  <= rgba_n;
			qv_q    <= qv_n;
		end
	end

endmodule

// ===== rtl/gif_tag_packet_unpacker_top.sv =====
// Tag stream unpacker. Each request is one 128-bit quadword; it is captured in an
// input register, decoded from there and its zero, one or two results are
// written into a four-entry result queue that drives the output port. A quadword
// enters every cycle as long as the queue has room for two results; the output
// port moves one result per cycle while out_ready is high, so ST descriptors and
// register-list quadwords, which can make two writes each, sustain a lower rate
// than the rest, which enter one per cycle. The first result of a quadword reaches
// the output port after it leaves the input register and is written into the queue.
module gif_tag_packet_unpacker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] qword_low,
	input  logic [63:0] qword_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  reg_addr,
	output logic [63:0] data_low,
	output logic [63:0] data_high,
	output logic        last
);

	logic                valid_s1;
	logic [63:0]         lo_s1, hi_s1;
	logic                fire;
	logic                pop;
	logic [2:0]          cnt_q, cnt_after;
	logic [1:0]          wr_q, rd_q;
	logic [1:0]          push;
	gtpu_pkg::gtpu_out_t res;
	gtpu_pkg::res_t      fifo_q [4];

	assign pop       = out_valid && out_ready;
	assign cnt_after = cnt_q - {2'b00, pop};
	assign fire      = valid_s1 && (cnt_after <= 3'd2);
	assign in_ready  = !valid_s1 || fire;
	assign push      = fire ? res.cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lo_s1 <= qword_low;
			hi_s1 <= qword_high;
		end
	end

	gtpu_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.qword_low  (lo_s1),
		.qword_high (hi_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
		end else begin
			cnt_q <= cnt_after + {1'b0, push};
			wr_q  <= wr_q + push;
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			fifo_q[wr_q] <= res.r0;
		end
		if (push == 2'd2) begin
			fifo_q[wr_q + 2'd1] <= res.r1;
		end
	end

	assign out_valid = (cnt_q != 3'd0);
	assign kind      = fifo_q[rd_q].kind;
	assign reg_addr  = fifo_q[rd_q].reg_addr;
	assign data_low  = fifo_q[rd_q].data_low;
	assign data_high = fifo_q[rd_q].data_high;
	assign last      = fifo_q[rd_q].last;

endmodule
